/* rtl/core/npcm_pkg.sv */
// npcm_pkg: request/result payload types, command codes and datapath widths
// for the nearest palette color mapper. no dependencies.
package npcm_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_MAP    = 2'd2;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned SUM_W   = 18;  // three squared 8-bit differences
  localparam int unsigned ROOT_W  = 9;   // floor sqrt of SUM_W bits, one stage per bit
  localparam int unsigned TRIAL_W = 20;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } npcm_req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] match_index;
    logic [8:0] match_distance;
    logic       palette_empty;
  } npcm_rsp_t;

  // travels alongside each palette entry through the datapath
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [INDEX_W-1:0] index;
  } npcm_tag_t;

endpackage

/* rtl/core/npcm_palette_ram.sv */
// npcm_palette_ram: palette store, one write port and one registered read port.
// the entry tag is delayed with the read data. depends on npcm_pkg.
module npcm_palette_ram import npcm_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [COLOR_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  input  npcm_tag_t          rd_tag,
  output logic [COLOR_W-1:0] rd_data_r,
  output npcm_tag_t          rd_tag_r
);

  logic [COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r <= rd_tag;
    end
  end

endmodule

/* rtl/core/npcm_dist_pipe.sv */
// npcm_dist_pipe: squared rgb distance followed by a floor square root,
// one bit per stage, one entry per cycle. depends on npcm_pkg.
module npcm_dist_pipe import npcm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         pix_red,
  input  logic [7:0]         pix_green,
  input  logic [7:0]         pix_blue,
  input  npcm_tag_t          in_tag,
  input  logic [COLOR_W-1:0] in_color,
  output npcm_tag_t          res_tag,
  output logic [COLOR_W-1:0] res_color,
  output logic [ROOT_W-1:0]  res_dist
);

  logic [7:0]         dr, dg, db;
  logic [15:0]        sq_r_r, sq_g_r, sq_b_r;
  npcm_tag_t          sq_tag_r;
  logic [COLOR_W-1:0] sq_color_r;

  logic [SUM_W-1:0]   rem_r   [ROOT_W+1];
  logic [ROOT_W-1:0]  root_r  [ROOT_W+1];
  npcm_tag_t          tag_r   [ROOT_W+1];
  logic [COLOR_W-1:0] color_r [ROOT_W+1];

  assign dr = (pix_red   > in_color[23:16]) ? pix_red   - in_color[23:16]
                                             : in_color[23:16] - pix_red;
  assign dg = (pix_green > in_color[15:8])  ? pix_green - in_color[15:8]
                                             : in_color[15:8] - pix_green;
  assign db = (pix_blue  > in_color[7:0])   ? pix_blue  - in_color[7:0]
                                             : in_color[7:0] - pix_blue;

  always_ff @(posedge clk) begin
    sq_r_r     <= 16'(dr) * 16'(dr);
    sq_g_r     <= 16'(dg) * 16'(dg);
    sq_b_r     <= 16'(db) * 16'(db);
    sq_color_r <= in_color;
    rem_r[0]   <= SUM_W'(sq_r_r) + SUM_W'(sq_g_r) + SUM_W'(sq_b_r);
    root_r[0]  <= '0;
    color_r[0] <= sq_color_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_tag_r <= '0;
      tag_r[0] <= '0;
    end else begin
      sq_tag_r <= in_tag;
      tag_r[0] <= sq_tag_r;
    end
  end

  // stage s decides root bit ROOT_W-1-s
  for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
    localparam int unsigned K = ROOT_W - 1 - s;
    logic [TRIAL_W-1:0] trial;
    logic               take;

    assign trial = (TRIAL_W'(root_r[s]) << (K + 1)) + (TRIAL_W'(1) << (2 * K));
    assign take  = TRIAL_W'(rem_r[s]) >= trial;

    always_ff @(posedge clk) begin
      rem_r[s+1]   <= take ? SUM_W'(TRIAL_W'(rem_r[s]) - trial) : rem_r[s];
      root_r[s+1]  <= take ? (root_r[s] | (ROOT_W'(1) << K)) : root_r[s];
      color_r[s+1] <= color_r[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s+1] <= '0;
      end else begin
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  assign res_tag   = tag_r[ROOT_W];
  assign res_color = color_r[ROOT_W];
  assign res_dist  = root_r[ROOT_W];

endmodule

/* rtl/core/nearest_palette_color_mapper_top.sv */
// nearest_palette_color_mapper_top: request decode, palette scan sequencer,
// best-match tracking and result register. depends on npcm_pkg,
// npcm_palette_ram and npcm_dist_pipe.
//
// usage: each request on in_data carries a command and an rgb triple. clear
// empties the palette, append writes the color at the end of the palette
// (dropped when full), map returns one result on out_data with the nearest
// palette color, its position and the floored euclidean distance, or
// palette_empty set when the palette holds nothing. clear and append give no
// result. a map reads one palette entry per cycle from the memory read port
// and then waits for the last entry to leave the distance pipe before the
// result is registered; no new request is taken meanwhile, as in_ready is
// high only while no map is in flight. the result register lets clear and
// append requests through while a result waits; a map finishing while the
// previous result still waits holds until that result is taken. reset
// empties the palette and drops any pending result; the palette memory
// itself is not cleared and needs no sweep.
module nearest_palette_color_mapper_top import npcm_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  npcm_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output npcm_rsp_t out_data
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW+7:0]      addr_ext;
  logic [7:0]         pix_red_r, pix_green_r, pix_blue_r;
  logic               found_r;
  logic [COLOR_W-1:0] best_color_r;
  logic [INDEX_W-1:0] best_index_r;
  logic [ROOT_W-1:0]  best_dist_r;
  logic               out_valid_r;
  npcm_rsp_t          out_data_r, out_data_nxt;

  logic               accept, map_start, scan_last, wr_en, out_load;
  npcm_tag_t          rd_tag, ram_tag, pipe_tag;
  logic [COLOR_W-1:0] ram_color, pipe_color;
  logic [ROOT_W-1:0]  pipe_dist;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign map_start = accept && (in_data.command == CMD_MAP);
  assign wr_en     = accept && (in_data.command == CMD_APPEND)
                     && (count_r < CW'(PALETTE_DEPTH));
  assign scan_last = (CW'(addr_r) + CW'(1)) == count_r;
  assign addr_ext  = {8'd0, addr_r};
  assign out_load  = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  assign rd_tag.valid = (state_r == ST_SCAN);
  assign rd_tag.last  = scan_last;
  assign rd_tag.index = addr_ext[7:0];

  npcm_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (count_r[AW-1:0]),
    .wr_data   ({in_data.in_red, in_data.in_green, in_data.in_blue}),
    .rd_en     (rd_tag.valid),
    .rd_addr   (addr_r),
    .rd_tag    (rd_tag),
    .rd_data_r (ram_color),
    .rd_tag_r  (ram_tag)
  );

  npcm_dist_pipe u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_red   (pix_red_r),
    .pix_green (pix_green_r),
    .pix_blue  (pix_blue_r),
    .in_tag    (ram_tag),
    .in_color  (ram_color),
    .res_tag   (pipe_tag),
    .res_color (pipe_color),
    .res_dist  (pipe_dist)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_CLEAR:  count_nxt = '0;
            CMD_APPEND: if (wr_en) count_nxt = count_r + CW'(1);
            CMD_MAP: begin
              addr_nxt  = '0;
              state_nxt = (count_r == '0) ? ST_FINISH : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_WAIT;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_WAIT: begin
        if (pipe_tag.valid && pipe_tag.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data_nxt.out_red        = found_r ? best_color_r[23:16] : 8'd0;
    out_data_nxt.out_green      = found_r ? best_color_r[15:8]  : 8'd0;
    out_data_nxt.out_blue       = found_r ? best_color_r[7:0]   : 8'd0;
    out_data_nxt.match_index    = found_r ? best_index_r        : 8'd0;
    out_data_nxt.match_distance = found_r ? best_dist_r         : 9'd0;
    out_data_nxt.palette_empty  = !found_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      addr_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
      if (map_start) begin
        found_r <= 1'b0;
      end else if (pipe_tag.valid && (!found_r || pipe_dist < best_dist_r)) begin
        found_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // first entry with strictly smaller floored distance wins
  always_ff @(posedge clk) begin
    if (map_start) begin
      pix_red_r   <= in_data.in_red;
      pix_green_r <= in_data.in_green;
      pix_blue_r  <= in_data.in_blue;
    end
    if (pipe_tag.valid && (!found_r || pipe_dist < best_dist_r)) begin
      best_color_r <= pipe_color;
      best_index_r <= pipe_tag.index;
      best_dist_r  <= pipe_dist;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pipe_only_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_tag.valid |-> (state_r == ST_SCAN || state_r == ST_WAIT))
    else $error("palette entry left the datapath outside a map scan");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(PALETTE_DEPTH))
    else $error("palette count beyond depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CW'(addr_r) < count_r))
    else $error("scan address beyond filled palette");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && !out_ready) |=> (state_r == ST_FINISH))
    else $error("map result dropped while result register full");

  a_finish_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && count_r != '0) |-> found_r)
    else $error("map over filled palette finished without a match");

endmodule

/* tb/nearest_palette_color_mapper_top_tb.sv */
// nearest_palette_color_mapper_top_tb: self-checking bench for the palette mapper,
// with an opening request table, random bursts, a built-in shadow palette and
// in-order result checking. depends on npcm_pkg and nearest_palette_color_mapper_top.
module nearest_palette_color_mapper_top_tb import npcm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PALETTE_SIZE   = 256;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int          RESET_CYCLES   = 8;
  localparam int          OPENING_LEN    = 21;
  localparam int          TOTAL_REQUESTS = 1600;
  localparam int          PHASE_LEN      = 540;
  localparam int          FILL_AT_A      = 400;
  localparam int          FILL_AT_B      = 1150;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = PALETTE_SIZE + 40;
  localparam int          LIMIT_CYCLES   = 2_000_000;

  typedef struct packed {
    npcm_req_t req;
    logic      pinned;
    npcm_rsp_t rsp;
  } opening_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  npcm_req_t in_data;
  logic      out_valid;
  logic      out_ready;
  npcm_rsp_t out_data;

  // shadow palette and outstanding map answers
  logic [23:0]  palette_rgb [PALETTE_SIZE];
  int unsigned  palette_len;
  npcm_rsp_t    results_due [$];
  npcm_rsp_t    oldest_due;
  opening_row_t opening_rows [OPENING_LEN];

  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned hold_countdown;

  nearest_palette_color_mapper_top #(.PALETTE_DEPTH(PALETTE_SIZE)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned r;
    r = $rtoi($sqrt(v));
    while (r * r > v) r--;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // applies one request to the shadow palette, returns the map answer if any
  task automatic apply_request(input npcm_req_t req, output logic has_rsp,
                               output npcm_rsp_t rsp);
    int          dr, dg, db;
    int unsigned entry_dist, best_dist;
    int          best_idx;
    has_rsp = 1'b0;
    rsp = '0;
    case (req.command)
      CMD_CLEAR: begin
        palette_len = 0;
      end
      CMD_APPEND: begin
        if (palette_len < PALETTE_SIZE) begin
          palette_rgb[palette_len] = {req.in_red, req.in_green, req.in_blue};
          palette_len++;
        end
      end
      CMD_MAP: begin
        has_rsp = 1'b1;
        best_idx = -1;
        best_dist = 0;
        for (int i = 0; i < int'(palette_len); i++) begin
          dr = int'(req.in_red) - int'(palette_rgb[i][23:16]);
          dg = int'(req.in_green) - int'(palette_rgb[i][15:8]);
          db = int'(req.in_blue) - int'(palette_rgb[i][7:0]);
          entry_dist = floor_root(dr * dr + dg * dg + db * db);
          // strictly smaller floored distance only, so the first entry wins ties
          if (best_idx < 0 || entry_dist < best_dist) begin
            best_idx = i;
            best_dist = entry_dist;
          end
        end
        if (best_idx < 0) begin
          rsp.palette_empty = 1'b1;
        end else begin
          {rsp.out_red, rsp.out_green, rsp.out_blue} = palette_rgb[best_idx];
          rsp.match_index    = 8'(best_idx);
          rsp.match_distance = 9'(best_dist);
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic npcm_req_t make_req(input logic [1:0] cmd, input logic [23:0] rgb);
    npcm_req_t req;
    req.command = cmd;
    {req.in_red, req.in_green, req.in_blue} = rgb;
    return req;
  endfunction

  function automatic opening_row_t row(input logic [1:0] cmd, input logic [23:0] rgb,
                                       input logic pinned, input logic [23:0] want_rgb,
                                       input logic [7:0] idx, input logic [8:0] want_dist,
                                       input logic empty);
    opening_row_t r;
    r.req = make_req(cmd, rgb);
    r.pinned = pinned;
    {r.rsp.out_red, r.rsp.out_green, r.rsp.out_blue} = want_rgb;
    r.rsp.match_index = idx;
    r.rsp.match_distance = want_dist;
    r.rsp.palette_empty = empty;
    return r;
  endfunction

  function automatic logic [7:0] rail_value();
    return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [23:0] pick_color();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return {rail_value(), rail_value(), rail_value()};
    if (roll < 35 && palette_len > 0) return palette_rgb[$urandom_range(0, palette_len - 1)];
    return 24'($urandom);
  endfunction

  function automatic logic [23:0] pick_pixel();
    int unsigned roll;
    logic [23:0] base;
    roll = $urandom_range(0, 99);
    if (roll < 35 && palette_len > 0) begin
      base = palette_rgb[$urandom_range(0, palette_len - 1)];
      return {nudge(base[23:16]), nudge(base[15:8]), nudge(base[7:0])};
    end
    if (roll < 55) return {rail_value(), rail_value(), rail_value()};
    return 24'($urandom);
  endfunction

  // offers one request, predicts at acceptance, then idles the sender at random
  task automatic send_request(input npcm_req_t req, input logic pinned,
                              input npcm_rsp_t pinned_rsp);
    logic        has_rsp;
    npcm_rsp_t   rsp;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    apply_request(req, has_rsp, rsp);
    if (has_rsp) results_due = {results_due, (pinned ? pinned_rsp : rsp)};
    requests_sent++;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < 60) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        oldest_due = results_due.pop_front();
        report_field("out_red", oldest_due.out_red, out_data.out_red);
        report_field("out_green", oldest_due.out_green, out_data.out_green);
        report_field("out_blue", oldest_due.out_blue, out_data.out_blue);
        report_field("match_index", oldest_due.match_index, out_data.match_index);
        report_field("match_distance", oldest_due.match_distance, out_data.match_distance);
        report_field("palette_empty", oldest_due.palette_empty, out_data.palette_empty);
      end
    end
  end

  // receiver: random backpressure, or a long hold when one is requested
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_countdown != 0) begin
        out_ready <= 1'b0;
        hold_countdown--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("nearest_palette_color_mapper_top_tb: errors");
    $finish;
  end

  initial begin
    int unsigned roll, n_colors, n_maps, fills_done, phase;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    error_count = 0;
    requests_sent = 0;
    hold_countdown = 0;
    palette_len = 0;
    fills_done = 0;
    phase = 0;
    sender_idle_pct = 22;
    receiver_idle_pct = 87;

    opening_rows[0]  = row(CMD_MAP,    24'h0C2238, 1, 24'h000000, 0, 0,   1);
    opening_rows[1]  = row(CMD_UNUSED, 24'hFFFFFF, 0, 24'h000000, 0, 0,   0);
    opening_rows[2]  = row(CMD_APPEND, 24'h000000, 0, 24'h000000, 0, 0,   0);
    opening_rows[3]  = row(CMD_MAP,    24'hFFFFFF, 1, 24'h000000, 0, 441, 0);
    opening_rows[4]  = row(CMD_APPEND, 24'hFFFFFF, 0, 24'h000000, 0, 0,   0);
    opening_rows[5]  = row(CMD_MAP,    24'hFFFFFF, 1, 24'hFFFFFF, 1, 0,   0);
    opening_rows[6]  = row(CMD_MAP,    24'h808080, 0, 24'h000000, 0, 0,   0);
    opening_rows[7]  = row(CMD_APPEND, 24'h000000, 0, 24'h000000, 0, 0,   0);
    opening_rows[8]  = row(CMD_MAP,    24'h010000, 1, 24'h000000, 0, 1,   0);
    opening_rows[9]  = row(CMD_MAP,    24'h00FF00, 0, 24'h000000, 0, 0,   0);
    opening_rows[10] = row(CMD_CLEAR,  24'hFFFFFF, 0, 24'h000000, 0, 0,   0);
    opening_rows[11] = row(CMD_MAP,    24'hC86432, 1, 24'h000000, 0, 0,   1);
    opening_rows[12] = row(CMD_APPEND, 24'h020100, 0, 24'h000000, 0, 0,   0);
    opening_rows[13] = row(CMD_APPEND, 24'h020000, 0, 24'h000000, 0, 0,   0);
    // both entries floor to 2, the earlier one must win
    opening_rows[14] = row(CMD_MAP,    24'h000000, 1, 24'h020100, 0, 2,   0);
    opening_rows[15] = row(CMD_APPEND, 24'hAA55AA, 0, 24'h000000, 0, 0,   0);
    opening_rows[16] = row(CMD_APPEND, 24'h55AA55, 0, 24'h000000, 0, 0,   0);
    opening_rows[17] = row(CMD_MAP,    24'hAA55AA, 1, 24'hAA55AA, 2, 0,   0);
    opening_rows[18] = row(CMD_UNUSED, 24'h000000, 0, 24'h000000, 0, 0,   0);
    opening_rows[19] = row(CMD_MAP,    24'h55AA55, 1, 24'h55AA55, 3, 0,   0);
    opening_rows[20] = row(CMD_CLEAR,  24'h000000, 0, 24'h000000, 0, 0,   0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < OPENING_LEN; i++) begin
      send_request(opening_rows[i].req, opening_rows[i].pinned, opening_rows[i].rsp);
    end

    while (requests_sent < TOTAL_REQUESTS) begin
      if (phase == 0 && requests_sent >= PHASE_LEN) begin
        phase = 1;
        // sender pauses until the block has answered everything
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        sender_idle_pct = 87;
        receiver_idle_pct = 22;
      end else if (phase == 1 && requests_sent >= 2 * PHASE_LEN) begin
        phase = 2;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        // long receiver hold while requests keep coming, so the input stalls
        hold_countdown = HOLD_CYCLES;
      end

      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_request(make_req(2'($urandom_range(0, 3)), 24'($urandom)), 1'b0, '0);
      end else begin
        if (roll < 86) send_request(make_req(CMD_CLEAR, 24'($urandom)), 1'b0, '0);
        if ((fills_done == 0 && requests_sent >= FILL_AT_A) ||
            (fills_done == 1 && requests_sent >= FILL_AT_B)) begin
          // fill the palette and push a few appends past the end
          n_colors = PALETTE_SIZE + $urandom_range(1, 6);
          fills_done++;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 5) n_colors = 0;
          else if (roll < 78) n_colors = $urandom_range(1, 8);
          else n_colors = $urandom_range(9, 48);
        end
        for (int i = 0; i < int'(n_colors); i++) begin
          send_request(make_req(CMD_APPEND, pick_color()), 1'b0, '0);
        end
        n_maps = $urandom_range(2, 10);
        for (int i = 0; i < int'(n_maps); i++) begin
          if ($urandom_range(0, 99) < 5) begin
            send_request(make_req($urandom_range(0, 1) ? CMD_UNUSED : CMD_APPEND,
                                  24'($urandom)), 1'b0, '0);
          end
          send_request(make_req(CMD_MAP, pick_pixel()), 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("nearest_palette_color_mapper_top_tb: clean");
    end else begin
      $display("nearest_palette_color_mapper_top_tb: errors");
    end
    $finish;
  end

endmodule
